[rtl/core/interval_bitwise_or_bounds_unit_assert.svh]
// assertion macros for the interval bitwise or bounds unit
`ifndef INTERVAL_BITWISE_OR_BOUNDS_UNIT_ASSERT_SVH
`define INTERVAL_BITWISE_OR_BOUNDS_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define IOBU_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("iobu check failed");

// next-cycle implication, off while reset is high
`define IOBU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("iobu check failed");

`endif

[rtl/core/iobu_pkg.sv]
// shared constants for the interval bitwise or bounds unit
package iobu_pkg;

  // default bound width
  localparam int DEF_WIDTH = 32;

  // operation codes on the func field
  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;

endpackage

[rtl/core/iobu_req_if.sv]
// request channel: func and the two input intervals
interface iobu_req_if #(
  parameter int WIDTH = iobu_pkg::DEF_WIDTH
);
  import iobu_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [WIDTH-1:0] a_lo;
  logic [WIDTH-1:0] a_hi;
  logic [WIDTH-1:0] b_lo;
  logic [WIDTH-1:0] b_hi;

  modport source (output valid, func, a_lo, a_hi, b_lo, b_hi, input ready);
  modport sink   (input valid, func, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

[rtl/core/iobu_rsp_if.sv]
// response channel: bounds of the or result and the empty flag
interface iobu_rsp_if #(
  parameter int WIDTH = iobu_pkg::DEF_WIDTH
);
  import iobu_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] r_lo;
  logic [WIDTH-1:0] r_hi;
  logic             r_empty;

  modport source (output valid, r_lo, r_hi, r_empty, input ready);
  modport sink   (input valid, r_lo, r_hi, r_empty, output ready);
endinterface

[rtl/core/interval_bitwise_or_bounds_unit.sv]
// interval bitwise or bounds unit: tightest [r_lo,r_hi] holding x|y over two intervals
//
// The unit takes one request at a time. In unsigned mode (func = 0) it runs one
// bit-serial pass over the operands through the load, scan and join states; the
// result is registered in the join state, or in a done state if the output
// register is still full. In signed mode (func = 1) each interval is split into
// its negative and its non-negative part and all four part pairs get their own
// pass. Every pass runs on the single scan engine, which looks at one bit of
// each of the four operands per cycle, most significant bit first, and produces
// one bit of the least and one bit of the greatest or result. The result sits
// in an output register; a new request is taken as soon as the engine is idle,
// even while that register still waits for its transfer. An empty input (lo
// above hi, compared in the mode's signedness) gives r_empty = 1 with both
// bounds zero.
`include "interval_bitwise_or_bounds_unit_assert.svh"

module interval_bitwise_or_bounds_unit #(
  parameter int WIDTH = iobu_pkg::DEF_WIDTH
) (
  input logic        clk,
  input logic        rst,
  iobu_req_if.sink   req,
  iobu_rsp_if.source rsp
);
  import iobu_pkg::*;

  localparam int              CW       = $clog2(WIDTH);
  localparam logic [CW-1:0]   LAST_BIT = CW'(WIDTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_JOIN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // control
  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [1:0]    pair;     // [1] part of a, [0] part of b; 0 negative, 1 non-negative
  logic          any;      // hull holds at least one part result

  // request copy, rotated one bit per scan cycle so it is aligned again after a pass
  logic             sgn;
  logic [WIDTH-1:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  // scan operands, shifted out msb first
  logic [WIDTH-1:0] x_lo, x_hi, y_lo, y_hi;

  // per-pass bit results and the running hull
  logic [WIDTH-1:0] res_lo, res_hi;
  logic [WIDTH-1:0] acc_lo, acc_hi;

  // scan flags
  logic dab, dcd;          // prefixes of lo/hi already differ
  logic mbrk, mside;       // least-or search done; mside set when the b side moved
  logic xbrk;              // greatest-or search done
  logic ea_dec, ea_gt;     // serial compare a_lo against a_hi
  logic eb_dec, eb_gt;     // serial compare b_lo against b_hi
  logic lt_dec, lt_flag;   // new least bound below the hull low
  logic gt_dec, gt_flag;   // new greatest bound above the hull high
  logic out_signed;

  // combinational
  logic             bit_a, bit_b, bit_c, bit_d, msb;
  logic             min_brk_a, min_brk_c, min_bit, max_brk, max_bit;
  logic             part_i, part_j, pair_ok, last_pass, empty_now, out_free, out_load;
  logic [WIDTH-1:0] ld_x_lo, ld_x_hi, ld_y_lo, ld_y_hi;
  logic [WIDTH-1:0] fin_lo, fin_hi;
  logic             take_lo, take_hi;

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    bit_a = x_lo[WIDTH-1];
    bit_b = x_hi[WIDTH-1];
    bit_c = y_lo[WIDTH-1];
    bit_d = y_hi[WIDTH-1];
    // sign bit is flipped for signed order compares
    msb   = (cnt == '0) && sgn;

    // least or: raise a zero bit of one low bound where the other has a one,
    // clearing everything below, as long as it stays within its high bound
    min_brk_a = !mbrk && !bit_a && bit_c && (dab || bit_b);
    min_brk_c = !mbrk && !(!bit_a && bit_c) && bit_a && !bit_c && (dcd || bit_d);
    min_bit   = mbrk ? (mside ? bit_a : bit_c) : (bit_a | bit_c);

    // greatest or: where both highs have a one, drop it in one and fill below
    // with ones, as long as that stays at or above its low bound
    max_brk = !xbrk && bit_b && bit_d && (dab || !bit_a || dcd || !bit_c);
    max_bit = xbrk | bit_b | bit_d;

    // part bounds for the coming pass; unsigned mode only ever uses pair zero
    part_i  = pair[1];
    part_j  = pair[0];
    ld_x_lo = (sgn && part_i && a_lo_q[WIDTH-1]) ? '0 : a_lo_q;
    ld_x_hi = (sgn && !part_i && !a_hi_q[WIDTH-1]) ? '1 : a_hi_q;
    ld_y_lo = (sgn && part_j && b_lo_q[WIDTH-1]) ? '0 : b_lo_q;
    ld_y_hi = (sgn && !part_j && !b_hi_q[WIDTH-1]) ? '1 : b_hi_q;

    // negative part exists when lo is negative, non-negative part when hi is not
    pair_ok = !sgn ||
              ((part_i ? !a_hi_q[WIDTH-1] : a_lo_q[WIDTH-1]) &&
               (part_j ? !b_hi_q[WIDTH-1] : b_lo_q[WIDTH-1]));
    last_pass = !sgn || (pair == 2'd3);
    empty_now = ea_gt | eb_gt;
    out_free  = !rsp.valid || rsp.ready;
    // finished result goes into the output register this cycle
    out_load  = (((state == ST_JOIN) && last_pass) || (state == ST_DONE)) && out_free;

    take_lo = pair_ok && (!any || lt_flag);
    take_hi = pair_ok && (!any || gt_flag);
    fin_lo  = (state == ST_JOIN && take_lo) ? res_lo : acc_lo;
    fin_hi  = (state == ST_JOIN && take_hi) ? res_hi : acc_hi;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pair      <= '0;
      any       <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            pair  <= '0;
            any   <= 1'b0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_BIT) begin
            state <= ST_JOIN;
          end
        end
        ST_JOIN: begin
          if (pair_ok) begin
            any <= 1'b1;
          end
          if (!last_pass) begin
            pair  <= pair + 1'b1;
            state <= ST_LOAD;
          end else if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      sgn    <= (req.func == FUNC_SIGNED);
      a_lo_q <= req.a_lo;
      a_hi_q <= req.a_hi;
      b_lo_q <= req.b_lo;
      b_hi_q <= req.b_hi;
    end

    if (state == ST_LOAD) begin
      x_lo    <= ld_x_lo;
      x_hi    <= ld_x_hi;
      y_lo    <= ld_y_lo;
      y_hi    <= ld_y_hi;
      dab     <= 1'b0;
      dcd     <= 1'b0;
      mbrk    <= 1'b0;
      mside   <= 1'b0;
      xbrk    <= 1'b0;
      ea_dec  <= 1'b0;
      ea_gt   <= 1'b0;
      eb_dec  <= 1'b0;
      eb_gt   <= 1'b0;
      lt_dec  <= 1'b0;
      lt_flag <= 1'b0;
      gt_dec  <= 1'b0;
      gt_flag <= 1'b0;
    end

    if (state == ST_SCAN) begin
      x_lo   <= {x_lo[WIDTH-2:0], 1'b0};
      x_hi   <= {x_hi[WIDTH-2:0], 1'b0};
      y_lo   <= {y_lo[WIDTH-2:0], 1'b0};
      y_hi   <= {y_hi[WIDTH-2:0], 1'b0};
      a_lo_q <= {a_lo_q[WIDTH-2:0], a_lo_q[WIDTH-1]};
      a_hi_q <= {a_hi_q[WIDTH-2:0], a_hi_q[WIDTH-1]};
      b_lo_q <= {b_lo_q[WIDTH-2:0], b_lo_q[WIDTH-1]};
      b_hi_q <= {b_hi_q[WIDTH-2:0], b_hi_q[WIDTH-1]};
      acc_lo <= {acc_lo[WIDTH-2:0], acc_lo[WIDTH-1]};
      acc_hi <= {acc_hi[WIDTH-2:0], acc_hi[WIDTH-1]};
      res_lo <= {res_lo[WIDTH-2:0], min_bit};
      res_hi <= {res_hi[WIDTH-2:0], max_bit};

      dab <= dab | (bit_a ^ bit_b);
      dcd <= dcd | (bit_c ^ bit_d);
      if (min_brk_a || min_brk_c) begin
        mbrk  <= 1'b1;
        mside <= min_brk_c;
      end
      if (max_brk) begin
        xbrk <= 1'b1;
      end

      // emptiness of the request intervals, first differing bit decides
      if (!ea_dec && ((a_lo_q[WIDTH-1] ^ msb) != (a_hi_q[WIDTH-1] ^ msb))) begin
        ea_dec <= 1'b1;
        ea_gt  <= a_lo_q[WIDTH-1] ^ msb;
      end
      if (!eb_dec && ((b_lo_q[WIDTH-1] ^ msb) != (b_hi_q[WIDTH-1] ^ msb))) begin
        eb_dec <= 1'b1;
        eb_gt  <= b_lo_q[WIDTH-1] ^ msb;
      end

      // hull compares against the rotating accumulators
      if (!lt_dec && ((min_bit ^ msb) != (acc_lo[WIDTH-1] ^ msb))) begin
        lt_dec  <= 1'b1;
        lt_flag <= !(min_bit ^ msb);
      end
      if (!gt_dec && ((max_bit ^ msb) != (acc_hi[WIDTH-1] ^ msb))) begin
        gt_dec  <= 1'b1;
        gt_flag <= max_bit ^ msb;
      end
    end

    if (state == ST_JOIN) begin
      acc_lo <= fin_lo;
      acc_hi <= fin_hi;
    end

    if (out_load) begin
      rsp.r_lo    <= empty_now ? '0 : fin_lo;
      rsp.r_hi    <= empty_now ? '0 : fin_hi;
      rsp.r_empty <= empty_now;
      out_signed  <= sgn;
    end
  end

  // every pass starts with its searches and compares open
  `IOBU_ASSERT_NOW(a_pass_start, clk, rst, (state == ST_SCAN) && (cnt == '0), !mbrk && !xbrk && !ea_dec && !eb_dec)
  // a non-empty request always leaves at least one part pair in the hull
  `IOBU_ASSERT_NOW(a_hull_filled, clk, rst, (state == ST_JOIN) && last_pass && !empty_now, any || pair_ok)
  // bounds are ordered in the requested signedness
  `IOBU_ASSERT_NOW(a_bounds_order, clk, rst, rsp.valid && !rsp.r_empty, out_signed ? ($signed(rsp.r_lo) <= $signed(rsp.r_hi)) : (rsp.r_lo <= rsp.r_hi))
  // an empty result carries zero bounds
  `IOBU_ASSERT_NOW(a_empty_zero, clk, rst, rsp.valid && rsp.r_empty, (rsp.r_lo == '0) && (rsp.r_hi == '0))

endmodule
